FILE: design/rbwm_pkg.sv
// Shared types and constants for the windowed-mean block.
`timescale 1ns / 1ps

package rbwm_pkg;

   // Width of the mean field and of the sample field on the ports.
   localparam int MEAN_BITS = 12;
   localparam int SAMPLE_FIELD_BITS = 12;
   localparam int WINDOW_FIELD_BITS = 7;
   localparam int TDATA_BITS = 16;

   // Window length after reset, before clamping to the buffer depth.
   localparam int WINDOW_RESET = 16;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV
   } state_type;

   // Controls broadcast to every cell of the sample chain.
   typedef struct packed {
      logic load;     // shift a new sample in, oldest one falls off the end
      logic rotate;   // circulate the chain one place toward the head
   } cell_ctrl_type;

endpackage

FILE: design/rbwm_cell.sv
// One storage cell of the circular sample chain.
`timescale 1ns / 1ps

module rbwm_cell #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rbwm_pkg::cell_ctrl_type     ctrl,
   input  logic [SAMPLE_BITS-1:0]      prev_data,
   input  logic [SAMPLE_BITS-1:0]      next_data,
   output logic [SAMPLE_BITS-1:0]      data
);

   logic [SAMPLE_BITS-1:0] data_ff;
   logic [SAMPLE_BITS-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.load) begin
         data_in = prev_data;
      end else if (ctrl.rotate) begin
         data_in = next_data;
      end
   end

   // The buffer starts out as zeros, so early means include them.
   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;

endmodule

FILE: design/rbwm_divider.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module rbwm_divider #(
   parameter int SUM_W = 19,
   parameter int WIN_W = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  dividend,
   input  logic [WIN_W-1:0]  divisor,
   output logic              done,
   output logic [SUM_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [WIN_W-1:0] rem_ff, rem_in;
   logic [WIN_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [WIN_W:0]   trial;
   logic [WIN_W:0]   diff;
   logic             fits;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CNT_W'(SUM_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so it fits in WIN_W bits.
         rem_in = fits ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: design/ring_buffer_window_mean.sv
// Moving average over the most recent samples with a configurable window.
// An accepted request is shifted into the chain, the chain circulates once while the window is
//    summed, the bit-serial divider runs, and the mean enters the result register once it is free.
// A new request is taken only after the mean of the last one has been loaded; the full circulation
//    of the sample chain and the bit-serial divider keep the block busy until then.
// Reset: synchronous, active high; clears every sample cell to zero, sets the window to 16
//    (clamped to BUFFER_DEPTH) and empties the result register.
`timescale 1ns / 1ps

module ring_buffer_window_mean #(
   parameter int BUFFER_DEPTH = 64,
   parameter int SAMPLE_BITS  = 12
) (
   input  logic        clock,
   input  logic        reset,

   // Window length register.
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,   // window_length

   // Request stream of converter samples.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,     // [11:0] sample, [15:12] zero

   // Response stream of means.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata      // [11:0] mean, [15:12] zero
);

   // The window register can hold every length from 1 to BUFFER_DEPTH.
   localparam int WIN_W = $clog2(BUFFER_DEPTH + 1);
   // Position counter used while the chain circulates.
   localparam int CNT_W = $clog2(BUFFER_DEPTH);
   // The sum of a full window of maximal samples fits here.
   localparam int SUM_W = SAMPLE_BITS + WIN_W;
   localparam int EXT_W = (SUM_W > rbwm_pkg::MEAN_BITS) ? SUM_W : rbwm_pkg::MEAN_BITS;
   localparam int WIN_RESET = (rbwm_pkg::WINDOW_RESET > BUFFER_DEPTH) ?
                              BUFFER_DEPTH : rbwm_pkg::WINDOW_RESET;

   // ---------------------------------------------------------------------------------------
   // Window register. Writes of zero hold the window at one; writes above the depth
   // saturate to the depth.
   // ---------------------------------------------------------------------------------------
   logic [WIN_W-1:0] window_ff, window_in;

   always_comb begin
      window_in = window_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            window_in = WIN_W'(1);
         end else if (32'(csr_wr_data) > BUFFER_DEPTH) begin
            window_in = WIN_W'(BUFFER_DEPTH);
         end else begin
            window_in = WIN_W'(csr_wr_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WIN_W'(WIN_RESET);
      end else begin
         window_ff <= window_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sequencer. An accepted sample is shifted into the head of the chain. The chain then
   // circulates BUFFER_DEPTH times toward the head, so the head shows the stored samples
   // from newest to oldest, and the chain ends up where it started. The first
   // window_length of them are summed, and the sum goes to the divider.
   // ---------------------------------------------------------------------------------------
   rbwm_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              req_accept;
   logic              last_pos;
   logic              out_free;
   logic              div_start;
   logic              div_done;
   logic [SUM_W-1:0]  div_quotient;
   logic              rsp_load;
   rbwm_pkg::cell_ctrl_type cell_ctrl;

   logic [SAMPLE_BITS-1:0] cell_data [BUFFER_DEPTH];
   logic [SAMPLE_BITS-1:0] new_sample;

   assign req_accept = req_tvalid && req_tready;
   assign last_pos   = (cnt_ff == CNT_W'(BUFFER_DEPTH - 1));
   assign out_free   = !rsp_tvalid || rsp_tready;
   assign new_sample = SAMPLE_BITS'(req_tdata[rbwm_pkg::SAMPLE_FIELD_BITS-1:0]);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rbwm_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = rbwm_pkg::ST_SUM;
            end
         end
         rbwm_pkg::ST_SUM: begin
            if (last_pos) begin
               state_in = rbwm_pkg::ST_DIV;
            end
         end
         rbwm_pkg::ST_DIV: begin
            if (div_done && out_free) begin
               state_in = rbwm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rbwm_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_tready       = 1'b0;
      cell_ctrl.load   = 1'b0;
      cell_ctrl.rotate = 1'b0;
      div_start        = 1'b0;
      rsp_load         = 1'b0;
      case (state_ff)
         rbwm_pkg::ST_IDLE: begin
            req_tready     = 1'b1;
            cell_ctrl.load = req_tvalid;
         end
         rbwm_pkg::ST_SUM: begin
            cell_ctrl.rotate = 1'b1;
            div_start        = last_pos;
         end
         rbwm_pkg::ST_DIV: begin
            rsp_load = div_done && out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Position counter and running sum.
   always_comb begin
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      if (req_accept) begin
         cnt_in = '0;
         sum_in = '0;
      end else if (state_ff == rbwm_pkg::ST_SUM) begin
         cnt_in = cnt_ff + 1'b1;
         if (WIN_W'(cnt_ff) < window_ff) begin
            sum_in = sum_ff + SUM_W'(cell_data[0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbwm_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   // ---------------------------------------------------------------------------------------
   // Sample chain. Cell 0 is the head and holds the newest sample at rest.
   // ---------------------------------------------------------------------------------------
   for (genvar i = 0; i < BUFFER_DEPTH; i++) begin : g_cell
      logic [SAMPLE_BITS-1:0] prev_data;
      logic [SAMPLE_BITS-1:0] next_data;

      if (i == 0) begin : g_head
         assign prev_data = new_sample;
      end else begin : g_body
         assign prev_data = cell_data[i-1];
      end

      if (i == BUFFER_DEPTH - 1) begin : g_tail
         assign next_data = cell_data[0];
      end else begin : g_link
         assign next_data = cell_data[i+1];
      end

      rbwm_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .prev_data (prev_data),
         .next_data (next_data),
         .data      (cell_data[i])
      );
   end

   // ---------------------------------------------------------------------------------------
   // Divider. The dividend includes the last addend taken on the final circulation step.
   // ---------------------------------------------------------------------------------------
   rbwm_divider #(
      .SUM_W (SUM_W),
      .WIN_W (WIN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (window_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // ---------------------------------------------------------------------------------------
   // Result register. The mean is masked to its field width.
   // ---------------------------------------------------------------------------------------
   logic [EXT_W-1:0]                  quotient_ext;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [rbwm_pkg::MEAN_BITS-1:0]    mean_ff, mean_in;

   assign quotient_ext = EXT_W'(div_quotient);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      mean_in      = mean_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         mean_in      = quotient_ext[rbwm_pkg::MEAN_BITS-1:0];
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mean_ff <= mean_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rbwm_pkg::TDATA_BITS'(mean_ff);

endmodule

FILE: design/rbwm_checker.sv
// Port-level checks of the windowed-mean block and the bind that attaches them.
`timescale 1ns / 1ps

module rbwm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // The result register is empty right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response keeps its mean.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // One sample is processed at a time: after an accepted transaction the block is busy.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

   // A new response only shows up while the block is busy finishing a sample.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("response appeared without a sample in progress");

   // The padding above the mean is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:12] == 4'h0)
      else $error("response padding not zero");

endmodule

bind ring_buffer_window_mean rbwm_checker u_rbwm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
